// ===== hw/rtl/dtl_pkg.sv =====
package dtl_pkg;

  localparam int ID_BITS       = 8;
  localparam int RATIO_BITS    = 10;
  localparam int GAP_BITS      = 9;
  localparam int FRAME_BITS    = 6;
  localparam int AREA_BITS     = 14;
  localparam int OUT_BITS      = 16;
  localparam int DEPTH_BITS    = 8;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam int M_TDATA_BITS  = ID_BITS + 8 * OUT_BITS;
  localparam int M_TUSER_BITS  = 2;

  localparam logic [RATIO_BITS-1:0] RATIO_HALF = RATIO_BITS'(512);
  localparam logic [RATIO_BITS-1:0] RATIO_LSBS = RATIO_BITS'(1023);

  localparam logic [RATIO_BITS-1:0] SPLIT_RATIO_RST   = RATIO_BITS'(563);
  localparam logic [GAP_BITS-1:0]   OUTER_MARGIN_RST  = GAP_BITS'(8);
  localparam logic [GAP_BITS-1:0]   INNER_SPACING_RST = GAP_BITS'(6);
  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST   = FRAME_BITS'(2);
  localparam logic [AREA_BITS-1:0]  AREA_LEFT_RST     = AREA_BITS'(0);
  localparam logic [AREA_BITS-1:0]  AREA_TOP_RST      = AREA_BITS'(0);
  localparam logic [AREA_BITS-1:0]  AREA_WIDTH_RST    = AREA_BITS'(1920);
  localparam logic [AREA_BITS-1:0]  AREA_HEIGHT_RST   = AREA_BITS'(1080);

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_SPLIT_RATIO   = 3'd0,
    REG_OUTER_MARGIN  = 3'd1,
    REG_INNER_SPACING = 3'd2,
    REG_FRAME_WIDTH   = 3'd3,
    REG_AREA_LEFT     = 3'd4,
    REG_AREA_TOP      = 3'd5,
    REG_AREA_WIDTH    = 3'd6,
    REG_AREA_HEIGHT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] split_ratio;
    logic [GAP_BITS-1:0]   outer_margin;
    logic [GAP_BITS-1:0]   inner_spacing;
    logic [FRAME_BITS-1:0] frame_width;
    logic [AREA_BITS-1:0]  area_left;
    logic [AREA_BITS-1:0]  area_top;
    logic [AREA_BITS-1:0]  area_width;
    logic [AREA_BITS-1:0]  area_height;
  } cfg_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  window_id;
    logic [OUT_BITS-1:0] tile_x;
    logic [OUT_BITS-1:0] tile_y;
    logic [OUT_BITS-1:0] tile_w;
    logic [OUT_BITS-1:0] tile_h;
    logic [OUT_BITS-1:0] frame_x;
    logic [OUT_BITS-1:0] frame_y;
    logic [OUT_BITS-1:0] frame_w;
    logic [OUT_BITS-1:0] frame_h;
    logic                frame_on;
    logic                use_focus_colour;
    logic                arrangement_done;
  } result_t;

endpackage

// ===== hw/rtl/dwindle_tile_layout.sv =====
// Channel   Dir  Payload                                            Accepted when
// s_        in   tdata: window_id; tlast: final_window;             s_tvalid && s_tready
//                tuser: has_focus
// m_        out  tdata: window_id, tile x/y/w/h, frame x/y/w/h;     m_tvalid && m_tready
//                tlast: arrangement_done; tuser: frame_on, focus
// apb       in   8 registers at 4*i, write in access phase          psel&&penable&&pwrite
//
// One window per cycle while m_ does not stall; m_tvalid rises as the result register loads.
// The split multiply, subtract and region update form one stage between the input
// register and the result register; the region state closes the loop in that stage.
// Reset is synchronous; no clearing pass, ready as soon as reset is released.
// A stalled m_ side holds the result register; the input register then fills and
// s_tready drops. Windows that give no result never load the result register, but
// still wait while a result is held.
module dwindle_tile_layout #(
  parameter int MAX_TILES  = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtl_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dtl_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dtl_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dtl_pkg::ID_BITS-1:0]        s_tdata,  // window_id
  input  logic                               s_tlast,
  input  logic [0:0]                         s_tuser,  // has_focus
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_window_id, tile_x, tile_y, tile_w, tile_h, frame_x, frame_y, frame_w, frame_h
  output logic [dtl_pkg::M_TDATA_BITS-1:0]   m_tdata,
  output logic                               m_tlast,
  output logic [dtl_pkg::M_TUSER_BITS-1:0]   m_tuser   // frame_on, use_focus_colour
);
  import dtl_pkg::*;

  cfg_t    cfg;
  result_t res, res_q;
  logic    emit;
  logic    in_valid;
  logic    advance;
  logic [ID_BITS-1:0] in_id;
  logic    in_last;
  logic    in_focus;

  dtl_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_id    <= s_tdata;
      in_last  <= s_tlast;
      in_focus <= s_tuser[0];
    end
  end

  dtl_split #(
    .MAX_TILES  (MAX_TILES),
    .COORD_BITS (COORD_BITS)
  ) u_split (
    .clk          (clk),
    .rst          (rst),
    .fire         (advance),
    .window_id    (in_id),
    .final_window (in_last),
    .has_focus    (in_focus),
    .cfg          (cfg),
    .emit         (emit),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.frame_h, res_q.frame_w, res_q.frame_y, res_q.frame_x,
                    res_q.tile_h, res_q.tile_w, res_q.tile_y, res_q.tile_x,
                    res_q.window_id};
  assign m_tlast = res_q.arrangement_done;
  assign m_tuser = {res_q.use_focus_colour, res_q.frame_on};

endmodule

// ===== hw/rtl/dtl_cfg_regs.sv =====
module dtl_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dtl_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dtl_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dtl_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output dtl_pkg::cfg_t                      cfg
);
  import dtl_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.split_ratio   <= SPLIT_RATIO_RST;
      cfg.outer_margin  <= OUTER_MARGIN_RST;
      cfg.inner_spacing <= INNER_SPACING_RST;
      cfg.frame_width   <= FRAME_WIDTH_RST;
      cfg.area_left     <= AREA_LEFT_RST;
      cfg.area_top      <= AREA_TOP_RST;
      cfg.area_width    <= AREA_WIDTH_RST;
      cfg.area_height   <= AREA_HEIGHT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SPLIT_RATIO:   cfg.split_ratio   <= pwdata[RATIO_BITS-1:0];
        REG_OUTER_MARGIN:  cfg.outer_margin  <= pwdata[GAP_BITS-1:0];
        REG_INNER_SPACING: cfg.inner_spacing <= pwdata[GAP_BITS-1:0];
        REG_FRAME_WIDTH:   cfg.frame_width   <= pwdata[FRAME_BITS-1:0];
        REG_AREA_LEFT:     cfg.area_left     <= pwdata[AREA_BITS-1:0];
        REG_AREA_TOP:      cfg.area_top      <= pwdata[AREA_BITS-1:0];
        REG_AREA_WIDTH:    cfg.area_width    <= pwdata[AREA_BITS-1:0];
        REG_AREA_HEIGHT:   cfg.area_height   <= pwdata[AREA_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPLIT_RATIO:   prdata = CFG_DATA_BITS'(cfg.split_ratio);
      REG_OUTER_MARGIN:  prdata = CFG_DATA_BITS'(cfg.outer_margin);
      REG_INNER_SPACING: prdata = CFG_DATA_BITS'(cfg.inner_spacing);
      REG_FRAME_WIDTH:   prdata = CFG_DATA_BITS'(cfg.frame_width);
      REG_AREA_LEFT:     prdata = CFG_DATA_BITS'(cfg.area_left);
      REG_AREA_TOP:      prdata = CFG_DATA_BITS'(cfg.area_top);
      REG_AREA_WIDTH:    prdata = CFG_DATA_BITS'(cfg.area_width);
      REG_AREA_HEIGHT:   prdata = CFG_DATA_BITS'(cfg.area_height);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/dtl_split.sv =====
module dtl_split #(
  parameter int MAX_TILES  = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [dtl_pkg::ID_BITS-1:0]  window_id,
  input  logic                         final_window,
  input  logic                         has_focus,
  input  dtl_pkg::cfg_t                cfg,
  output logic                         emit,
  output dtl_pkg::result_t             res
);
  import dtl_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int PW = COORD_BITS + RATIO_BITS + 1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_LIMIT = DEPTH_BITS'(MAX_TILES - 1);

  typedef logic signed [W-1:0]  coord_t;
  typedef logic signed [PW-1:0] prod_t;

  coord_t region_x, region_y, region_w, region_h;
  logic [DEPTH_BITS-1:0] split_depth;
  logic in_progress;
  logic area_empty;

  coord_t open_x, open_y, open_w, open_h;
  coord_t cur_x, cur_y, cur_w, cur_h;
  coord_t span, slice, ig, half_ig;
  coord_t nxt_x, nxt_y, nxt_w, nxt_h;
  coord_t t_x, t_y, t_w, t_h;
  logic   cur_empty, fill;
  logic [DEPTH_BITS-1:0] depth;
  logic [RATIO_BITS-1:0] ratio;
  prod_t  prod, rounded, scaled;
  logic [OUT_BITS-1:0] x16, y16, w16, h16, bw16;

  always_comb begin
    open_x = W'(cfg.area_left) + W'(cfg.outer_margin);
    open_y = W'(cfg.area_top) + W'(cfg.outer_margin);
    open_w = W'(cfg.area_width) - W'({cfg.outer_margin, 1'b0});
    open_h = W'(cfg.area_height) - W'({cfg.outer_margin, 1'b0});

    cur_x     = in_progress ? region_x : open_x;
    cur_y     = in_progress ? region_y : open_y;
    cur_w     = in_progress ? region_w : open_w;
    cur_h     = in_progress ? region_h : open_h;
    depth     = in_progress ? split_depth : '0;
    cur_empty = in_progress ? area_empty
                            : ((open_w <= coord_t'(0)) || (open_h <= coord_t'(0)));
    fill      = final_window || (depth >= DEPTH_LIMIT);

    ratio   = (depth == '0) ? cfg.split_ratio : RATIO_HALF;
    span    = depth[0] ? cur_h : cur_w;
    prod    = PW'(span) * PW'($signed({1'b0, ratio}));
    rounded = prod + (prod[PW-1] ? PW'(RATIO_LSBS) : '0);
    scaled  = rounded >>> RATIO_BITS;
    half_ig = W'(cfg.inner_spacing >> 1);
    ig      = W'(cfg.inner_spacing);
    slice   = W'(scaled) - half_ig;

    nxt_x = cur_x;
    nxt_y = cur_y;
    nxt_w = cur_w;
    nxt_h = cur_h;
    t_x   = cur_x;
    t_y   = cur_y;
    t_w   = cur_w;
    t_h   = cur_h;
    if (!fill) begin
      if (depth[0]) begin
        t_h   = slice;
        nxt_y = cur_y + slice + ig;
        nxt_h = cur_h - slice - ig;
      end else begin
        t_w   = slice;
        nxt_x = cur_x + slice + ig;
        nxt_w = cur_w - slice - ig;
      end
    end

    x16  = OUT_BITS'(t_x);
    y16  = OUT_BITS'(t_y);
    w16  = OUT_BITS'(t_w);
    h16  = OUT_BITS'(t_h);
    bw16 = OUT_BITS'(cfg.frame_width);

    emit                 = !cur_empty;
    res.window_id        = window_id;
    res.tile_x           = x16;
    res.tile_y           = y16;
    res.tile_w           = w16;
    res.tile_h           = h16;
    res.arrangement_done = fill;
    if (cfg.frame_width != '0) begin
      res.frame_x          = x16 - bw16;
      res.frame_y          = y16 - bw16;
      res.frame_w          = w16 + {bw16[OUT_BITS-2:0], 1'b0};
      res.frame_h          = h16 + {bw16[OUT_BITS-2:0], 1'b0};
      res.frame_on         = 1'b1;
      res.use_focus_colour = has_focus;
    end else begin
      res.frame_x          = '0;
      res.frame_y          = '0;
      res.frame_w          = '0;
      res.frame_h          = '0;
      res.frame_on         = 1'b0;
      res.use_focus_colour = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress <= 1'b0;
      area_empty  <= 1'b0;
      split_depth <= '0;
    end else if (fire) begin
      split_depth <= depth;
      region_x    <= cur_x;
      region_y    <= cur_y;
      region_w    <= cur_w;
      region_h    <= cur_h;
      if (cur_empty) begin
        in_progress <= !final_window;
        area_empty  <= 1'b1;
      end else if (fill) begin
        in_progress <= !final_window;
        area_empty  <= !final_window;
      end else begin
        in_progress <= 1'b1;
        area_empty  <= 1'b0;
        region_x    <= nxt_x;
        region_y    <= nxt_y;
        region_w    <= nxt_w;
        region_h    <= nxt_h;
        split_depth <= depth + DEPTH_BITS'(1);
      end
    end
  end

  a_close_on_last: assert property (@(posedge clk) disable iff (rst)
    fire && final_window |=> !in_progress)
    else $error("arrangement still open after last window");

  a_overflow_blocks: assert property (@(posedge clk) disable iff (rst)
    fire && emit && fill && !final_window |=> in_progress && area_empty)
    else $error("results not suppressed after tile limit");

  a_depth_step: assert property (@(posedge clk) disable iff (rst)
    fire && emit && !fill |=> split_depth == $past(depth) + DEPTH_BITS'(1))
    else $error("split depth did not advance by one");

endmodule

// ===== tb/dwindle_tile_layout_tb.sv =====
`timescale 1ns / 100ps

module dwindle_tile_layout_tb;
  import dtl_pkg::*;

  localparam int LIMIT = 800_000;

  class dwindle_scoreboard;
    logic [RATIO_BITS-1:0] ratio;
    logic [GAP_BITS-1:0]   margin;
    logic [GAP_BITS-1:0]   spacing;
    logic [FRAME_BITS-1:0] border;
    logic [AREA_BITS-1:0]  left;
    logic [AREA_BITS-1:0]  top;
    logic [AREA_BITS-1:0]  width;
    logic [AREA_BITS-1:0]  height;
    logic signed [OUT_BITS-1:0] rx, ry, rw, rh;
    logic [DEPTH_BITS-1:0] depth;
    bit open;
    bit empty;
    result_t placements[$];
    int errors;

    function new();
      ratio   = SPLIT_RATIO_RST;
      margin  = OUTER_MARGIN_RST;
      spacing = INNER_SPACING_RST;
      border  = FRAME_WIDTH_RST;
      left    = AREA_LEFT_RST;
      top     = AREA_TOP_RST;
      width   = AREA_WIDTH_RST;
      height  = AREA_HEIGHT_RST;
      rx = '0; ry = '0; rw = '0; rh = '0;
      depth = '0;
      open = 0;
      empty = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] v);
      case (idx)
        REG_SPLIT_RATIO:   ratio   = v[RATIO_BITS-1:0];
        REG_OUTER_MARGIN:  margin  = v[GAP_BITS-1:0];
        REG_INNER_SPACING: spacing = v[GAP_BITS-1:0];
        REG_FRAME_WIDTH:   border  = v[FRAME_BITS-1:0];
        REG_AREA_LEFT:     left    = v[AREA_BITS-1:0];
        REG_AREA_TOP:      top     = v[AREA_BITS-1:0];
        REG_AREA_WIDTH:    width   = v[AREA_BITS-1:0];
        REG_AREA_HEIGHT:   height  = v[AREA_BITS-1:0];
        default: ;
      endcase
    endfunction

    // truncate toward zero
    function logic signed [OUT_BITS-1:0] fraction(logic signed [OUT_BITS-1:0] len,
                                                   logic [RATIO_BITS-1:0] r);
      longint p;
      longint q;
      p = longint'(len) * longint'(r);
      if (p >= 0) q = p >>> 10;
      else q = -((-p) >>> 10);
      return q[OUT_BITS-1:0];
    endfunction

    function result_t place(logic [ID_BITS-1:0] id, bit focus,
                            logic signed [OUT_BITS-1:0] x, logic signed [OUT_BITS-1:0] y,
                            logic signed [OUT_BITS-1:0] w, logic signed [OUT_BITS-1:0] h,
                            bit done);
      result_t t;
      longint bw;
      bw = longint'(border);
      t.window_id = id;
      t.tile_x = x;
      t.tile_y = y;
      t.tile_w = w;
      t.tile_h = h;
      if (border != 0) begin
        t.frame_x = OUT_BITS'(longint'(x) - bw);
        t.frame_y = OUT_BITS'(longint'(y) - bw);
        t.frame_w = OUT_BITS'(longint'(w) + 2 * bw);
        t.frame_h = OUT_BITS'(longint'(h) + 2 * bw);
        t.frame_on = 1'b1;
        t.use_focus_colour = focus;
      end else begin
        t.frame_x = '0;
        t.frame_y = '0;
        t.frame_w = '0;
        t.frame_h = '0;
        t.frame_on = 1'b0;
        t.use_focus_colour = 1'b0;
      end
      t.arrangement_done = done;
      return t;
    endfunction

    function void note_window(logic [ID_BITS-1:0] id, bit last, bit focus);
      logic [RATIO_BITS-1:0] r;
      longint cut;
      if (!open) begin
        rx = OUT_BITS'(longint'(left) + longint'(margin));
        ry = OUT_BITS'(longint'(top) + longint'(margin));
        rw = OUT_BITS'(longint'(width) - 2 * longint'(margin));
        rh = OUT_BITS'(longint'(height) - 2 * longint'(margin));
        depth = '0;
        empty = (rw <= 0) || (rh <= 0);
        open = 1;
      end
      if (empty) begin
        if (last) open = 0;
        return;
      end
      if (last || depth >= DEPTH_BITS'(255)) begin
        placements.push_back(place(id, focus, rx, ry, rw, rh, 1'b1));
        if (last) open = 0;
        else empty = 1;
        return;
      end
      r = (depth == 0) ? ratio : RATIO_HALF;
      if (!depth[0]) begin
        cut = longint'(fraction(rw, r)) - longint'(spacing) / 2;
        placements.push_back(place(id, focus, rx, ry, OUT_BITS'(cut), rh, 1'b0));
        rx = OUT_BITS'(longint'(rx) + cut + longint'(spacing));
        rw = OUT_BITS'(longint'(rw) - cut - longint'(spacing));
      end else begin
        cut = longint'(fraction(rh, r)) - longint'(spacing) / 2;
        placements.push_back(place(id, focus, rx, ry, rw, OUT_BITS'(cut), 1'b0));
        ry = OUT_BITS'(longint'(ry) + cut + longint'(spacing));
        rh = OUT_BITS'(longint'(rh) - cut - longint'(spacing));
      end
      depth = depth + 1'b1;
    endfunction

    function void compare_field(string name, logic [OUT_BITS-1:0] e, logic [OUT_BITS-1:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, actual %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_placement(result_t got);
      result_t want;
      if (placements.size() == 0) begin
        $error("unexpected placement for window_id %0h", got.window_id);
        errors++;
        return;
      end
      want = placements.pop_front();
      compare_field("out_window_id", OUT_BITS'(want.window_id), OUT_BITS'(got.window_id));
      compare_field("tile_x", want.tile_x, got.tile_x);
      compare_field("tile_y", want.tile_y, got.tile_y);
      compare_field("tile_w", want.tile_w, got.tile_w);
      compare_field("tile_h", want.tile_h, got.tile_h);
      compare_field("frame_x", want.frame_x, got.frame_x);
      compare_field("frame_y", want.frame_y, got.frame_y);
      compare_field("frame_w", want.frame_w, got.frame_w);
      compare_field("frame_h", want.frame_h, got.frame_h);
      compare_field("frame_on", OUT_BITS'(want.frame_on), OUT_BITS'(got.frame_on));
      compare_field("use_focus_colour", OUT_BITS'(want.use_focus_colour),
                    OUT_BITS'(got.use_focus_colour));
      compare_field("arrangement_done", OUT_BITS'(want.arrangement_done),
                    OUT_BITS'(got.arrangement_done));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic pready;
  logic s_tvalid;
  logic s_tready;
  logic [ID_BITS-1:0] s_tdata;
  logic s_tlast;
  logic [0:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic m_tlast;
  logic [M_TUSER_BITS-1:0] m_tuser;

  dwindle_scoreboard sb;
  bit calm;

  dwindle_tile_layout DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.window_id        = m_tdata[ID_BITS-1:0];
      got.tile_x           = m_tdata[ID_BITS + 0 * OUT_BITS +: OUT_BITS];
      got.tile_y           = m_tdata[ID_BITS + 1 * OUT_BITS +: OUT_BITS];
      got.tile_w           = m_tdata[ID_BITS + 2 * OUT_BITS +: OUT_BITS];
      got.tile_h           = m_tdata[ID_BITS + 3 * OUT_BITS +: OUT_BITS];
      got.frame_x          = m_tdata[ID_BITS + 4 * OUT_BITS +: OUT_BITS];
      got.frame_y          = m_tdata[ID_BITS + 5 * OUT_BITS +: OUT_BITS];
      got.frame_w          = m_tdata[ID_BITS + 6 * OUT_BITS +: OUT_BITS];
      got.frame_h          = m_tdata[ID_BITS + 7 * OUT_BITS +: OUT_BITS];
      got.frame_on         = m_tuser[0];
      got.use_focus_colour = m_tuser[1];
      got.arrangement_done = m_tlast;
      sb.check_placement(got);
    end
  end

  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_window(logic [ID_BITS-1:0] id, bit last, bit focus);
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    s_tlast  <= last;
    s_tuser  <= focus;
    do @(posedge clk); while (!s_tready);
    sb.note_window(id, last, focus);
  endtask

  task automatic pace();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // hold off until every placement is back, then let windows without result clear
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.placements.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic int unsigned pick(int unsigned top_val, int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top_val;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_SPLIT_RATIO, pick(1023, 102, 922));
    write_reg(REG_OUTER_MARGIN, pick(511, 0, 64));
    write_reg(REG_INNER_SPACING, pick(511, 0, 40));
    write_reg(REG_FRAME_WIDTH, pick(63, 0, 32));
    write_reg(REG_AREA_LEFT, pick(16383, 0, 16383));
    write_reg(REG_AREA_TOP, pick(16383, 0, 16383));
    write_reg(REG_AREA_WIDTH, pick(16383, 200, 16383));
    write_reg(REG_AREA_HEIGHT, pick(16383, 200, 16383));
  endtask

  initial begin
    int togo;
    int n;
    bit last;
    bit long_pending;
    sb = new();
    calm = 0;
    togo = 0;
    long_pending = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    s_tuser <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: splits at every depth parity, then a lone last window
    send_window(8'h00, 0, 1);
    send_window(8'hFF, 0, 0);
    send_window(8'h55, 0, 1);
    send_window(8'hAA, 0, 0);
    send_window(8'h0F, 1, 1);
    send_window(8'hF0, 1, 0);
    drain();

    // border off, ratio at its maximum, widest inner spacing, no outer margin, area at the far corner
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_SPLIT_RATIO, 1023);
    write_reg(REG_INNER_SPACING, 511);
    write_reg(REG_OUTER_MARGIN, 0);
    write_reg(REG_AREA_LEFT, 16383);
    write_reg(REG_AREA_TOP, 16383);
    write_reg(REG_AREA_WIDTH, 16383);
    write_reg(REG_AREA_HEIGHT, 16383);
    send_window(8'h01, 0, 1);
    send_window(8'h02, 0, 0);
    send_window(8'h03, 0, 1);
    send_window(8'h04, 1, 1);
    drain();

    write_reg(REG_SPLIT_RATIO, 0);
    write_reg(REG_FRAME_WIDTH, 63);
    write_reg(REG_INNER_SPACING, 0);
    write_reg(REG_OUTER_MARGIN, 511);
    send_window(8'h10, 0, 1);
    send_window(8'h11, 0, 0);
    send_window(8'h12, 1, 1);
    drain();

    // shrunk area collapses to nothing
    write_reg(REG_AREA_WIDTH, 1022);
    send_window(8'h20, 0, 1);
    send_window(8'h21, 0, 0);
    send_window(8'h22, 1, 1);
    drain();

    // change live settings in the middle of an arrangement
    write_reg(REG_OUTER_MARGIN, 8);
    write_reg(REG_AREA_WIDTH, 1920);
    write_reg(REG_AREA_LEFT, 0);
    write_reg(REG_AREA_TOP, 0);
    write_reg(REG_AREA_HEIGHT, 1080);
    send_window(8'h30, 0, 0);
    send_window(8'h31, 0, 1);
    drain();
    write_reg(REG_SPLIT_RATIO, 102);
    write_reg(REG_INNER_SPACING, 256);
    write_reg(REG_FRAME_WIDTH, 32);
    send_window(8'h32, 0, 1);
    send_window(8'h33, 1, 0);

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 3 && sb.open) send_window(8'($urandom), 1, 0);
      drain();
      random_config();
      if (phase == 3) begin
        write_reg(REG_OUTER_MARGIN, 4);
        write_reg(REG_AREA_WIDTH, 4000);
        write_reg(REG_AREA_HEIGHT, 3000);
        long_pending = 1;
        togo = 0;
      end
      calm = (phase >= 10);
      n = (phase == 3) ? 300 : 140;
      repeat (n) begin
        if (togo == 0) begin
          togo = long_pending ? 260 : $urandom_range(1, 12);
          long_pending = 0;
        end
        last = (togo == 1);
        if (togo <= 4 && $urandom_range(0, 15) == 0) last = ~last;
        togo = last ? 0 : togo - 1;
        pace();
        send_window(8'($urandom), last, 1'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dtl_pkg.sv
hw/rtl/dtl_cfg_regs.sv
hw/rtl/dtl_split.sv
hw/rtl/dwindle_tile_layout.sv
tb/dwindle_tile_layout_tb.sv
